[hdl/bfb_pkg.sv]
// ----------------------------------------------------------------------------
// bfb_pkg
// shared types and constants of the beacon frame builder
// ----------------------------------------------------------------------------
`default_nettype none

package bfb_pkg;

  localparam int MAX_SSID_BYTES_DEFAULT = 32;
  localparam int SSID_REGS   = 4;
  localparam int HDR_BYTES   = 38;
  localparam int FRAME_WORDS = 9;
  localparam int FRAME_BITS  = FRAME_WORDS * 64;
  localparam int WIDX_W      = 4;
  localparam int CFG_IDX_W   = 3;

  localparam logic [7:0]  FC_BEACON       = 8'h80;
  localparam logic [47:0] BCAST_ADDR      = 48'hFFFF_FFFF_FFFF;
  localparam logic [7:0]  BEACON_INTERVAL = 8'h64;
  localparam logic [7:0]  CAPABILITY_INFO = 8'h01;
  localparam logic [7:0]  SSID_ELEM_ID    = 8'h00;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BSSID        = 3'd0,
    REG_SSID_LENGTH  = 3'd1,
    REG_SSID_0_7     = 3'd2,
    REG_SSID_8_15    = 3'd3,
    REG_SSID_16_23   = 3'd4,
    REG_SSID_24_31   = 3'd5
  } bfb_reg_e;

  typedef struct packed {
    logic [47:0]                  bssid;
    logic [5:0]                   ssid_length;
    logic [SSID_REGS-1:0][63:0]   ssid;
  } bfb_cfg_t;

  typedef struct packed {
    logic [63:0] frame_word;
    logic [3:0]  valid_bytes;
    logic        last_word;
    logic [6:0]  frame_length;
  } bfb_word_t;

endpackage

`default_nettype wire

[hdl/beacon_frame_builder.sv]
// ----------------------------------------------------------------------------
// beacon_frame_builder
// one 802.11 beacon per timestamp beat, streamed as little-endian 64-bit words
// ----------------------------------------------------------------------------
// path: each input beat enters the job register, and its words then enter the output register
// throughput: one word per cycle unless the output stalls, a beacon is 5 to 9 words (38 +
//   ssid length bytes), the word sequencer sets the rate; the next input beat is taken
//   in the cycle its predecessor's last word enters the output register
// reset: synchronous, clears the configuration, the sequence counter, the
//   word index and both valids; data registers are not reset
`default_nettype none

module beacon_frame_builder #(
  parameter int MAX_SSID_BYTES = bfb_pkg::MAX_SSID_BYTES_DEFAULT
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  // input stream
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  input  wire logic [63:0]                    s_axis_tdata,  // timestamp_us
  // output stream
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  output logic [79:0]                         m_axis_tdata,  // frame_word[63:0],
                                                             // valid_bytes[67:64],
                                                             // frame_length[74:68],
                                                             // zero pad[79:75]
  output logic                                m_axis_tlast,  // last_word
  // configuration writes
  input  wire logic                           cfg_we,
  input  wire logic [bfb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [63:0]                    cfg_wdata
);
  import bfb_pkg::*;

  bfb_cfg_t           cfg;
  bfb_word_t          word;

  // frame job register: one beacon being walked word by word
  logic               job_valid;
  logic [63:0]        job_ts;
  logic [11:0]        job_seq;
  logic [WIDX_W-1:0]  word_idx;
  logic [11:0]        seq;

  logic               in_fire;
  logic               out_load;
  logic               job_done;

  bfb_cfg_regs #(
    .MAX_SSID_BYTES (MAX_SSID_BYTES)
  ) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  bfb_word_builder u_word (
    .cfg          (cfg),
    .timestamp_us (job_ts),
    .seq          (job_seq),
    .word_idx     (word_idx),
    .word         (word)
  );

  // output register loads while a beacon is in progress and it is empty or its beat is being taken
  assign out_load      = job_valid && (!m_axis_tvalid || m_axis_tready);
  assign job_done      = out_load && word.last_word;
  assign s_axis_tready = !job_valid || job_done;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
      word_idx  <= '0;
      seq       <= '0;
    end else if (in_fire) begin
      job_valid <= 1'b1;
      word_idx  <= '0;
      seq       <= seq + 12'd1;  // wraps after 4095
    end else if (job_done) begin
      job_valid <= 1'b0;
    end else if (out_load) begin
      word_idx  <= word_idx + WIDX_W'(1);
    end
  end

  // beacon carries the count held before its beat
  always_ff @(posedge clk) begin
    if (in_fire) begin
      job_ts  <= s_axis_tdata;
      job_seq <= seq;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_axis_tdata <= {5'b00000, word.frame_length, word.valid_bytes, word.frame_word};
      m_axis_tlast <= word.last_word;
    end
  end

  // sequence counter steps once per accepted beacon
  a_seq_step: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> seq == $past(seq) + 12'd1)
    else $error("sequence counter did not advance");

  // only the final word of a beacon may be short
  a_short_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tdata[67:64] != 4'd8) |-> m_axis_tlast)
    else $error("short word before end of frame");

  // a word carries between one and eight bytes
  a_valid_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[67:64] != 4'd0) && (m_axis_tdata[67:64] <= 4'd8))
    else $error("valid byte count out of range");

  // frame length stays within header plus maximum ssid
  a_len_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[74:68] >= 7'(HDR_BYTES)) &&
                      (m_axis_tdata[74:68] <= 7'(HDR_BYTES + MAX_SSID_BYTES)))
    else $error("frame length out of range");

  // word index holds while the output side stalls
  a_idx_hold: assert property (@(posedge clk) disable iff (rst)
    job_valid && !out_load && !in_fire |=> $stable(word_idx))
    else $error("word index moved during stall");

endmodule

`default_nettype wire

[hdl/bfb_cfg_regs.sv]
// ----------------------------------------------------------------------------
// bfb_cfg_regs
// configuration register file, ssid length saturates at the maximum
// ----------------------------------------------------------------------------
`default_nettype none

module bfb_cfg_regs #(
  parameter int MAX_SSID_BYTES = bfb_pkg::MAX_SSID_BYTES_DEFAULT
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [bfb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [63:0]                    cfg_wdata,
  output bfb_pkg::bfb_cfg_t                   cfg
);
  import bfb_pkg::*;

  logic [5:0] len_in;
  logic [5:0] len_sat;

  assign len_in  = cfg_wdata[5:0];
  assign len_sat = (len_in > 6'(MAX_SSID_BYTES)) ? 6'(MAX_SSID_BYTES) : len_in;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BSSID:       cfg.bssid       <= cfg_wdata[47:0];
        REG_SSID_LENGTH: cfg.ssid_length <= len_sat;
        REG_SSID_0_7:    cfg.ssid[0]     <= cfg_wdata;
        REG_SSID_8_15:   cfg.ssid[1]     <= cfg_wdata;
        REG_SSID_16_23:  cfg.ssid[2]     <= cfg_wdata;
        REG_SSID_24_31:  cfg.ssid[3]     <= cfg_wdata;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

[hdl/bfb_word_builder.sv]
// ----------------------------------------------------------------------------
// bfb_word_builder
// lays out the beacon bytes and selects one 64-bit word of the frame
// ----------------------------------------------------------------------------
`default_nettype none

module bfb_word_builder (
  input  wire bfb_pkg::bfb_cfg_t             cfg,
  input  wire logic [63:0]                   timestamp_us,
  input  wire logic [11:0]                   seq,
  input  wire logic [bfb_pkg::WIDX_W-1:0]    word_idx,
  output bfb_pkg::bfb_word_t                 word
);
  import bfb_pkg::*;

  logic [FRAME_BITS-1:0]          frame;
  logic [SSID_REGS*64-1:0]        ssid_all;
  logic [FRAME_WORDS-1:0][63:0]   words;
  logic [6:0]                     len;
  logic [6:0]                     rem;
  logic [WIDX_W-1:0]              last_idx;

  assign ssid_all = cfg.ssid;
  assign words    = frame;

  always_comb begin
    frame = '0;
    frame[7:0]     = FC_BEACON;
    frame[79:32]   = BCAST_ADDR;
    frame[127:80]  = cfg.bssid;
    frame[175:128] = cfg.bssid;
    frame[191:176] = {seq, 4'h0};
    frame[255:192] = timestamp_us;
    frame[263:256] = BEACON_INTERVAL;
    frame[279:272] = CAPABILITY_INFO;
    frame[295:288] = SSID_ELEM_ID;
    frame[303:296] = {2'b00, cfg.ssid_length};
    // ssid bytes past the configured length stay zero
    for (int i = 0; i < SSID_REGS * 8; i++) begin
      if (6'(i) < cfg.ssid_length) begin
        frame[HDR_BYTES*8 + i*8 +: 8] = ssid_all[i*8 +: 8];
      end
    end
  end

  assign len      = 7'(HDR_BYTES) + {1'b0, cfg.ssid_length};
  assign last_idx = WIDX_W'((len - 7'd1) >> 3);
  assign rem      = len - {word_idx, 3'b000};

  always_comb begin
    word.frame_word   = (word_idx < WIDX_W'(FRAME_WORDS)) ? words[word_idx] : '0;
    word.valid_bytes  = (rem > 7'd8) ? 4'd8 : rem[3:0];
    word.last_word    = (word_idx == last_idx);
    word.frame_length = len;
  end

endmodule

`default_nettype wire
